[sv/gf2n_pkg.sv]
package gf2n_pkg;

    // Width of the operand and result fields on the ports.
    localparam int DATA_BITS = 32;

    // Default datapath width.
    localparam int WORD_BITS_DEF = 32;

    // Register reset values.
    localparam logic [5:0]  FIELD_DEGREE_RST   = 6'd8;
    localparam logic [31:0] REDUCTION_POLY_RST = 32'd29;

    // Register indexes on the configuration port.
    localparam logic REG_FIELD_DEGREE   = 1'b0;
    localparam logic REG_REDUCTION_POLY = 1'b1;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_MUL = 2'd1,
        ACT_MOD = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_MOD,
        ST_FLUSH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MOD_IDLE,
        MOD_NORM,
        MOD_REDUCE
    } mod_state_t;

    // Status that an iterative unit reports to the controller.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

[sv/gf2n_mul_serial.sv]
module gf2n_mul_serial #(
    parameter int WORD_BITS = gf2n_pkg::WORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [$clog2(WORD_BITS+1)-1:0]   n,
    input  logic [WORD_BITS-1:0]             op_a,
    input  logic [WORD_BITS-1:0]             op_b,
    input  logic [WORD_BITS-1:0]             poly,
    output gf2n_pkg::unit_stat_t             stat,
    output logic [WORD_BITS-1:0]             product
);

    localparam int NW = $clog2(WORD_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [NW-1:0]        cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [WORD_BITS-1:0] p_reg, p_next;
    logic [WORD_BITS-1:0] poly_reg, poly_next;
    logic [WORD_BITS-1:0] mask_reg, mask_next;
    logic [WORD_BITS-1:0] top_reg, top_next;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] top;
    logic                 carry;

    // Field mask covers the low n bits; top marks bit n-1.
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            mask[i] = (NW'(i) < n);
            top[i]  = (NW'(i + 1) == n);
        end
    end

    assign carry = |(a_reg & top_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        poly_next = poly_reg;
        mask_next = mask_reg;
        top_next  = top_reg;
        if (start) begin
            a_next    = op_a & mask;
            b_next    = op_b & mask;
            poly_next = poly & mask;
            mask_next = mask;
            top_next  = top;
            p_next    = '0;
            cnt_next  = n;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                p_next = p_reg ^ a_reg;
            end
            b_next = {1'b0, b_reg[WORD_BITS-1:1]};
            a_next = ({a_reg[WORD_BITS-2:0], 1'b0} & mask_reg) ^ (carry ? poly_reg : '0);
            cnt_next = cnt_reg - NW'(1);
            if (cnt_reg == NW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        p_reg    <= p_next;
        poly_reg <= poly_next;
        mask_reg <= mask_next;
        top_reg  <= top_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = p_reg;

endmodule

[sv/gf2n_mod_serial.sv]
module gf2n_mod_serial #(
    parameter int WORD_BITS = gf2n_pkg::WORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] op_a,
    input  logic [WORD_BITS-1:0] op_b,
    output gf2n_pkg::unit_stat_t stat,
    output logic [WORD_BITS-1:0] remainder
);

    localparam int KW = $clog2(WORD_BITS);

    gf2n_pkg::mod_state_t state_reg, state_next;
    logic                 done_reg, done_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] bs_reg, bs_next;
    logic [WORD_BITS-1:0] msk_reg, msk_next;

    // The divisor is first shifted up until its leading term sits in the top
    // bit, counting the shifts. It then walks back down one place a cycle and
    // is subtracted wherever the remainder has a term at its leading position.
    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        k_next     = k_reg;
        rem_next   = rem_reg;
        bs_next    = bs_reg;
        msk_next   = msk_reg;
        case (state_reg)
            gf2n_pkg::MOD_IDLE: begin
                if (start) begin
                    rem_next   = op_a;
                    bs_next    = op_b;
                    k_next     = '0;
                    state_next = gf2n_pkg::MOD_NORM;
                end
            end
            gf2n_pkg::MOD_NORM: begin
                if (bs_reg[WORD_BITS-1]) begin
                    msk_next   = {1'b1, {(WORD_BITS-1){1'b0}}};
                    state_next = gf2n_pkg::MOD_REDUCE;
                end else begin
                    bs_next = {bs_reg[WORD_BITS-2:0], 1'b0};
                    k_next  = k_reg + KW'(1);
                end
            end
            gf2n_pkg::MOD_REDUCE: begin
                if (|(rem_reg & msk_reg)) begin
                    rem_next = rem_reg ^ bs_reg;
                end
                bs_next  = {1'b0, bs_reg[WORD_BITS-1:1]};
                msk_next = {1'b0, msk_reg[WORD_BITS-1:1]};
                if (k_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = gf2n_pkg::MOD_IDLE;
                end else begin
                    k_next = k_reg - KW'(1);
                end
            end
            default: begin
                state_next = gf2n_pkg::MOD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gf2n_pkg::MOD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        k_reg   <= k_next;
        rem_reg <= rem_next;
        bs_reg  <= bs_next;
        msk_reg <= msk_next;
    end

    assign stat.busy = (state_reg != gf2n_pkg::MOD_IDLE);
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

[sv/gf2n_arithmetic_unit.sv]
// GF(2^n) arithmetic unit.
// Input words arrive on the s_ stream: s_tuser carries the action (add, field
// multiply, polynomial mod) and s_tdata the two operands. Each word yields one
// result word on the m_ stream: m_tdata holds the result and m_tuser the
// divide error flag, set only for a mod of a nonzero dividend by a zero divisor.
// field_degree and reduction_poly are written through the cfg_ port; the user
// must write them only while the unit is idle, as the block does not enforce
// it. A write lands at the clock edge where cfg_wr_en is high.
// Add, and every case that needs no iteration, skip the serial units;
// multiply runs the bit-serial shift-and-add loop that takes one multiplier
// bit a cycle; mod runs the divisor alignment shifter followed by one
// subtract step a cycle.
// One word is worked on at a time; s_tready is high while the controller is
// idle, so a new word can be taken in the cycle after the previous result
// moved to the output register, even while that result still waits there.
// If the receiver stalls, a second finished result is held inside until the
// output register frees up. Reset clears all handshake state and restores
// field_degree to 8 and reduction_poly to 29.
module gf2n_arithmetic_unit #(
    parameter int WORD_BITS = gf2n_pkg::WORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic [1:0]  s_tuser,   // action [1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result [31:0]
    output logic [0:0]  m_tuser    // divide_error [0]
);

    localparam int NW = $clog2(WORD_BITS + 1);
    localparam int DB = gf2n_pkg::DATA_BITS;
    localparam logic [5:0] W_DEG = 6'(WORD_BITS);

    // Configuration registers.
    logic [5:0]  field_degree_reg;
    logic [31:0] reduction_poly_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_degree_reg   <= gf2n_pkg::FIELD_DEGREE_RST;
            reduction_poly_reg <= gf2n_pkg::REDUCTION_POLY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                gf2n_pkg::REG_FIELD_DEGREE:   field_degree_reg   <= cfg_wdata[5:0];
                gf2n_pkg::REG_REDUCTION_POLY: reduction_poly_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Degrees beyond the datapath width act as the full width.
    logic [NW-1:0] n_eff;
    assign n_eff = (field_degree_reg > W_DEG) ? NW'(WORD_BITS) : NW'(field_degree_reg);

    // Operands are cut down to the datapath width.
    logic [WORD_BITS-1:0] a_w, b_w;
    assign a_w = s_tdata[WORD_BITS-1:0];
    assign b_w = s_tdata[DB+WORD_BITS-1:DB];

    gf2n_pkg::ctrl_state_t state_reg, state_next;
    logic [WORD_BITS-1:0]  res_reg, res_next;
    logic                  err_reg, err_next;
    logic                  m_valid_reg, m_valid_next;
    logic [DB-1:0]         m_data_reg, m_data_next;
    logic                  m_err_reg, m_err_next;
    logic                  accept;
    logic                  mul_start, mod_start;
    gf2n_pkg::unit_stat_t  mul_stat, mod_stat;
    logic [WORD_BITS-1:0]  mul_product, mod_remainder;

    assign s_tready = (state_reg == gf2n_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    gf2n_mul_serial #(
        .WORD_BITS(WORD_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .n       (n_eff),
        .op_a    (a_w),
        .op_b    (b_w),
        .poly    (reduction_poly_reg[WORD_BITS-1:0]),
        .stat    (mul_stat),
        .product (mul_product)
    );

    gf2n_mod_serial #(
        .WORD_BITS(WORD_BITS)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .op_a      (a_w),
        .op_b      (b_w),
        .stat      (mod_stat),
        .remainder (mod_remainder)
    );

    // Controller: decodes the action, runs the serial unit when one is needed
    // and hands the finished result to the output register.
    always_comb begin
        state_next   = state_reg;
        res_next     = res_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_err_next   = m_err_reg;
        mul_start    = 1'b0;
        mod_start    = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            gf2n_pkg::ST_IDLE: begin
                if (accept) begin
                    res_next   = '0;
                    err_next   = 1'b0;
                    state_next = gf2n_pkg::ST_FLUSH;
                    case (s_tuser)
                        gf2n_pkg::ACT_ADD: begin
                            res_next = a_w ^ b_w;
                        end
                        gf2n_pkg::ACT_MUL: begin
                            // A zero field degree makes every product zero.
                            if (n_eff != '0) begin
                                mul_start  = 1'b1;
                                state_next = gf2n_pkg::ST_MUL;
                            end
                        end
                        gf2n_pkg::ACT_MOD: begin
                            // A zero dividend gives zero; a zero divisor
                            // with a nonzero dividend gives zero and raises the error flag.
                            if (a_w != '0) begin
                                if (b_w == '0) begin
                                    err_next = 1'b1;
                                end else begin
                                    mod_start  = 1'b1;
                                    state_next = gf2n_pkg::ST_MOD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            gf2n_pkg::ST_MUL: begin
                if (mul_stat.done) begin
                    res_next   = mul_product;
                    state_next = gf2n_pkg::ST_FLUSH;
                end
            end
            gf2n_pkg::ST_MOD: begin
                if (mod_stat.done) begin
                    res_next   = mod_remainder;
                    state_next = gf2n_pkg::ST_FLUSH;
                end
            end
            gf2n_pkg::ST_FLUSH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = DB'(res_reg);
                    m_err_next   = err_reg;
                    state_next   = gf2n_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gf2n_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gf2n_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        res_reg    <= res_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
        m_err_reg  <= m_err_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_err_reg;

`ifndef SYNTHESIS
    // No serial unit may still be running while a new word can be taken.
    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gf2n_pkg::ST_IDLE) |-> (!mul_stat.busy && !mod_stat.busy))
        else $error("serial unit busy while controller idle");

    // A multiply completion is only seen while the controller waits for it.
    a_mul_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.done |-> (state_reg == gf2n_pkg::ST_MUL))
        else $error("multiply finished outside its wait state");

    // A mod completion is only seen while the controller waits for it.
    a_mod_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_stat.done |-> (state_reg == gf2n_pkg::ST_MOD))
        else $error("mod finished outside its wait state");

    // A divide error always comes with a zero result.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_err_reg) |-> (m_data_reg == '0))
        else $error("divide error with nonzero result");

    // Starting a unit always leaves the idle state.
    a_start_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_start || mod_start) |=> (state_reg == gf2n_pkg::ST_MUL ||
                                      state_reg == gf2n_pkg::ST_MOD))
        else $error("unit started without entering a wait state");
`endif

endmodule
